>>> rtl/wsd_pkg.sv
// Shared constants, types and the arctangent table of the wind speed and direction block.
package wsd_pkg;

  localparam int CORDIC_STEPS    = 18;
  localparam int COMPONENT_WIDTH = 16;

  localparam int TABLE_LEN = 24;
  localparam int NSTEPS    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

  localparam int FRAC_BITS = 16;
  localparam int ANG_FRAC  = 12;
  localparam int CODE_W    = 16;
  localparam int CMP_W     = (COMPONENT_WIDTH > CODE_W) ? COMPONENT_WIDTH : CODE_W;

  // Vector word: component plus fraction bits plus CORDIC growth and sign.
  localparam int XW = COMPONENT_WIDTH + FRAC_BITS + 3;
  // Angle word: centidegrees times 4096, signed.
  localparam int ZW = 29;

  localparam int SAT_BIT = FRAC_BITS + 17;
  localparam int MAG_W   = (XW > SAT_BIT + 1) ? XW : SAT_BIT + 1;
  localparam int GAIN_W  = 24;
  localparam int PROD_W  = SAT_BIT + GAIN_W;
  localparam int SPD_SHIFT = FRAC_BITS + 24;
  localparam int DIR_W   = 16;
  localparam int SPD_W   = 16;

  localparam logic [GAIN_W-1:0]  GAIN_Q24   = 24'd10187623;
  localparam logic signed [ZW-1:0] HALF_TURN = 29'sd73728000;
  localparam logic signed [ZW-1:0] FULL_TURN = 29'sd147456000;
  localparam logic signed [ZW-1:0] ANG_HALF_LSB = 29'sd2048;
  localparam logic [DIR_W-1:0]   DIR_WRAP   = 16'd36000;
  localparam logic [DIR_W-1:0]   DIR_CALM   = 16'd18000;
  localparam logic [SPD_W-1:0]   SPD_MAX    = 16'hFFFF;

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_MISSING_CODE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_BAD_CODE     = 1'b1;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 miss;
    logic                 calm;
  } vec_t;

  typedef struct packed {
    logic [DIR_W-1:0] direction;
    logic [SPD_W-1:0] speed;
    logic             is_missing;
  } res_t;

  // atan(2^-i) in centidegrees times 4096, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0:  a = 29'sd18432000;
      1:  a = 29'sd10881045;
      2:  a = 29'sd5749245;
      3:  a = 29'sd2918407;
      4:  a = 29'sd1464867;
      5:  a = 29'sd733147;
      6:  a = 29'sd366663;
      7:  a = 29'sd183343;
      8:  a = 29'sd91673;
      9:  a = 29'sd45837;
      10: a = 29'sd22918;
      11: a = 29'sd11459;
      12: a = 29'sd5730;
      13: a = 29'sd2865;
      14: a = 29'sd1432;
      15: a = 29'sd716;
      16: a = 29'sd358;
      17: a = 29'sd179;
      18: a = 29'sd90;
      19: a = 29'sd45;
      20: a = 29'sd22;
      21: a = 29'sd11;
      22: a = 29'sd6;
      23: a = 29'sd3;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/wsd_if.sv
// Valid/ready channel interfaces for wind components in and speed and direction out.
interface wsd_in_if;
  import wsd_pkg::*;
  logic                              valid;
  logic                              ready;
  logic signed [COMPONENT_WIDTH-1:0] wind_east;
  logic signed [COMPONENT_WIDTH-1:0] wind_north;

  modport source (output valid, output wind_east, output wind_north, input ready);
  modport sink   (input valid, input wind_east, input wind_north, output ready);
endinterface

interface wsd_out_if;
  import wsd_pkg::*;
  logic             valid;
  logic             ready;
  logic [DIR_W-1:0] direction;
  logic [SPD_W-1:0] speed;
  logic             is_missing;

  modport source (output valid, output direction, output speed, output is_missing,
                  input ready);
  modport sink   (input valid, input direction, input speed, input is_missing,
                  output ready);
endinterface

>>> rtl/wsd_cordic.sv
// Unrolled CORDIC vectoring pipeline, one rotation per register stage.
module wsd_cordic (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  wsd_pkg::vec_t in_vec,
  output logic          out_valid,
  output wsd_pkg::vec_t out_vec
);
  import wsd_pkg::*;

  vec_t        stg [NSTEPS];
  logic [NSTEPS-1:0] vld;

  for (genvar i = 0; i < NSTEPS; i++) begin : g_step
    vec_t cur;
    vec_t nxt;
    logic cur_v;

    if (i == 0) begin : g_first
      assign cur   = in_vec;
      assign cur_v = in_valid;
    end else begin : g_rest
      assign cur   = stg[i-1];
      assign cur_v = vld[i-1];
    end

    always_comb begin
      nxt = cur;
      // rotate towards the x axis; arithmetic shift floors negatives
      if (cur.y > 0) begin
        nxt.x = cur.x + (cur.y >>> i);
        nxt.y = cur.y - (cur.x >>> i);
        nxt.z = cur.z + atan_entry(i);
      end else begin
        nxt.x = cur.x - (cur.y >>> i);
        nxt.y = cur.y + (cur.x >>> i);
        nxt.z = cur.z - atan_entry(i);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg[i] <= nxt;
      end
    end
  end

  assign out_valid = vld[NSTEPS-1];
  assign out_vec   = stg[NSTEPS-1];

endmodule

>>> rtl/wind_speed_direction_from_uv_top.sv
// Top level: wind direction and speed from u and v components via a CORDIC pipeline.
//
// Takes one grid point (wind_east, wind_north) per cycle and returns the direction the
// wind blows from in 0.01 degree (0..35999) and the speed in 0.01 m/s, saturating at
// 65535. A component equal to missing_code (register 0) or bad_code (register 1) gives
// is_missing with zero direction and speed; calm input gives direction 18000. The input
// beat lands in the pre-rotation stage, then passes one stage per CORDIC iteration, a
// wrap and gain-multiply stage, a rounding stage and the output register. Throughput is
// one item per cycle while the skid is empty, set by the fully unrolled iteration stages.
// A skid register behind the output takes the beat in flight when the sink stalls, so
// input ready comes straight from a register. While the skid is full the whole pipeline
// holds and input ready stays low.
module wind_speed_direction_from_uv_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [wsd_pkg::CFG_INDEX_W-1:0]     wr_index,
  input  logic [wsd_pkg::CODE_W-1:0]          wr_data,
  wsd_in_if.sink                              wind_in,
  wsd_out_if.source                           wind_out
);
  import wsd_pkg::*;

  logic signed [CODE_W-1:0] missing_code;
  logic signed [CODE_W-1:0] bad_code;

  logic en;
  logic out_free;

  // pre-rotation stage
  logic signed [CMP_W-1:0] u_c, v_c, mc_c, bc_c;
  logic signed [XW-1:0]    u_x, v_x;
  vec_t                    pre_next;
  vec_t                    pre;
  logic                    pre_valid;

  // CORDIC output
  vec_t cd_vec;
  logic cd_valid;

  // wrap and multiply stage
  logic signed [ZW-1:0]    t_wrap, t_sum;
  logic [MAG_W-1:0]        mag;
  logic                    pa_valid, pa_miss, pa_calm, pa_sat;
  logic [DIR_W-1:0]        pa_round;
  logic [PROD_W-1:0]       pa_prod;

  // rounding stage
  logic [PROD_W:0]         rsum;
  logic [PROD_W-SPD_SHIFT:0] spd_wide;
  res_t                    pb_next;
  res_t                    pb;
  logic                    pb_valid;

  // output register and skid
  res_t out_q, skid;
  logic out_valid, skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      missing_code <= -16'sd32768;
      bad_code     <= 16'sd32767;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MISSING_CODE: missing_code <= wr_data;
        REG_BAD_CODE:     bad_code     <= wr_data;
        default: ;
      endcase
    end
  end

  // stall everything while the skid holds a beat
  assign en            = !skid_valid;
  assign wind_in.ready = en;

  always_comb begin
    u_c  = CMP_W'(wind_in.wind_east);
    v_c  = CMP_W'(wind_in.wind_north);
    mc_c = CMP_W'(missing_code);
    bc_c = CMP_W'(bad_code);
    u_x  = XW'(wind_in.wind_east) <<< FRAC_BITS;
    v_x  = XW'(wind_in.wind_north) <<< FRAC_BITS;
    pre_next.miss = (u_c == mc_c) || (u_c == bc_c) || (v_c == mc_c) || (v_c == bc_c);
    pre_next.calm = (u_c == '0) && (v_c == '0);
    // x = -v, y = -u; fold into the right half plane
    if (wind_in.wind_north > 0) begin
      pre_next.x = v_x;
      pre_next.y = u_x;
      pre_next.z = HALF_TURN;
    end else begin
      pre_next.x = -v_x;
      pre_next.y = -u_x;
      pre_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_valid <= 1'b0;
    end else if (en) begin
      pre_valid <= wind_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre <= pre_next;
    end
  end

  wsd_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pre_valid),
    .in_vec    (pre),
    .out_valid (cd_valid),
    .out_vec   (cd_vec)
  );

  always_comb begin
    t_wrap = (cd_vec.z < 0) ? cd_vec.z + FULL_TURN : cd_vec.z;
    t_sum  = t_wrap + ANG_HALF_LSB;
    mag    = (cd_vec.x > 0) ? MAG_W'(cd_vec.x) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pa_valid <= 1'b0;
    end else if (en) begin
      pa_valid <= cd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_miss  <= cd_vec.miss;
      pa_calm  <= cd_vec.calm;
      pa_round <= t_sum[ANG_FRAC+DIR_W-1:ANG_FRAC];
      pa_sat   <= |mag[MAG_W-1:SAT_BIT];
      pa_prod  <= mag[SAT_BIT-1:0] * GAIN_Q24;
    end
  end

  always_comb begin
    rsum     = {1'b0, pa_prod} + ((PROD_W+1)'(1) << (SPD_SHIFT - 1));
    spd_wide = rsum[PROD_W:SPD_SHIFT];
    pb_next.is_missing = pa_miss;
    if (pa_miss) begin
      pb_next.direction = '0;
      pb_next.speed     = '0;
    end else if (pa_calm) begin
      pb_next.direction = DIR_CALM;
      pb_next.speed     = '0;
    end else begin
      pb_next.direction = (pa_round >= DIR_WRAP) ? pa_round - DIR_WRAP : pa_round;
      if (pa_sat || (|spd_wide[PROD_W-SPD_SHIFT:SPD_W])) begin
        pb_next.speed = SPD_MAX;
      end else begin
        pb_next.speed = spd_wide[SPD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pb_valid <= 1'b0;
    end else if (en) begin
      pb_valid <= pa_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pb <= pb_next;
    end
  end

  assign out_free = !out_valid || wind_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= pb_valid;
      end
    end else if (pb_valid && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_q <= skid_valid ? skid : pb;
    end else if (pb_valid && en) begin
      skid <= pb;
    end
  end

  assign wind_out.valid      = out_valid;
  assign wind_out.direction  = out_q.direction;
  assign wind_out.speed      = out_q.speed;
  assign wind_out.is_missing = out_q.is_missing;

  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while the output register is empty");

  a_skid_held_on_stall: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_valid && !wind_out.ready |=> skid_valid)
    else $error("skid beat dropped during a stall");

  a_missing_zeroes: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_q.is_missing |-> out_q.direction == '0 && out_q.speed == '0)
    else $error("missing result carries non-zero direction or speed");

  a_direction_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_q.direction < DIR_WRAP)
    else $error("direction outside one turn");

endmodule
